FILE: rtl/edmc_pkg.sv
// shared types, constants and the microcode rom for the encoder distance motor controller
// used by edmc_seq and encoder_distance_motor_ctrl; no dependencies
package edmc_pkg;

    localparam int UPC_W = 4;

    localparam logic [7:0]  STRAIGHT_TAG   = 8'hFF;
    localparam logic [31:0] TURN_MASK      = 32'hF0F0_0000;
    localparam logic [7:0]  CODE_LEFT      = 8'hF0;
    localparam logic [7:0]  CODE_RIGHT     = 8'h0F;

    localparam logic [31:0] QUAD_LIN       = 32'd69003;
    localparam logic [31:0] QUAD_OFFSET    = 32'd16480;
    localparam logic [31:0] STRAIGHT_DIV   = 32'd10000;
    localparam logic [31:0] TURN_MUL       = 32'd100;
    localparam logic [31:0] TURN_DIV       = 32'd173;
    // floor(2^32 / divisor): estimate is exact or one low
    localparam logic [31:0] RECIP_STRAIGHT = 32'd429496;
    localparam logic [31:0] RECIP_TURN     = 32'd24826400;

    localparam logic [15:0] PWM_RESET      = 16'd75;
    localparam logic [15:0] PWM_MAX        = 16'hFFFF;
    localparam logic [7:0]  MARGIN_RESET   = 8'd1;

    localparam logic [UPC_W-1:0] STEP_DISPATCH = 4'd0;
    localparam logic [UPC_W-1:0] STEP_STRAIGHT = 4'd1;
    localparam logic [UPC_W-1:0] STEP_TURN     = 4'd7;
    localparam logic [UPC_W-1:0] STEP_FIN      = 4'd11;

    typedef enum logic [1:0] {
        A_D,
        A_PROD_LO,
        A_PROD_HI,
        A_ACC
    } a_sel_t;

    typedef enum logic [2:0] {
        B_D6,
        B_QUAD_LIN,
        B_TURN_MUL,
        B_STRAIGHT_DIV,
        B_TURN_DIV,
        B_RECIP_STRAIGHT,
        B_RECIP_TURN
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUM
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH
    } jmp_t;

    typedef enum logic {
        DIV_STRAIGHT,
        DIV_TURN
    } div_sel_t;

    typedef struct packed {
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        logic             mul_en;
        acc_op_t          acc_op;
        logic             quot_ld;
        logic             rem_ld;
        div_sel_t         div_sel;
        jmp_t             jmp;
        logic [UPC_W-1:0] target;
        logic             fin;
    } ctrl_t;

    typedef struct packed {
        logic is_straight;
        logic is_turn;
        logic out_blocked;
    } seq_cond_t;

    function automatic ctrl_t micro_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '0;
        unique case (addr)
            4'd0: begin
                w.jmp = J_DISPATCH;
            end
            // straight: q = 6*d*d + 69003*d - 16480, then q / 10000
            4'd1: begin
                w.a_sel = A_D;
                w.b_sel = B_D6;
                w.mul_en = 1'b1;
            end
            4'd2: begin
                w.acc_op = ACC_LOAD;
                w.a_sel = A_D;
                w.b_sel = B_QUAD_LIN;
                w.mul_en = 1'b1;
            end
            4'd3: begin
                w.acc_op = ACC_SUM;
            end
            4'd4: begin
                w.a_sel = A_ACC;
                w.b_sel = B_RECIP_STRAIGHT;
                w.mul_en = 1'b1;
            end
            4'd5: begin
                w.quot_ld = 1'b1;
                w.a_sel = A_PROD_HI;
                w.b_sel = B_STRAIGHT_DIV;
                w.mul_en = 1'b1;
            end
            4'd6: begin
                w.rem_ld = 1'b1;
                w.div_sel = DIV_STRAIGHT;
                w.jmp = J_GOTO;
                w.target = STEP_FIN;
            end
            // turn: (d*100) / 173
            4'd7: begin
                w.a_sel = A_D;
                w.b_sel = B_TURN_MUL;
                w.mul_en = 1'b1;
            end
            4'd8: begin
                w.acc_op = ACC_LOAD;
                w.a_sel = A_PROD_LO;
                w.b_sel = B_RECIP_TURN;
                w.mul_en = 1'b1;
            end
            4'd9: begin
                w.quot_ld = 1'b1;
                w.a_sel = A_PROD_HI;
                w.b_sel = B_TURN_DIV;
                w.mul_en = 1'b1;
            end
            4'd10: begin
                w.rem_ld = 1'b1;
                w.div_sel = DIV_TURN;
            end
            4'd11: begin
                w.fin = 1'b1;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/edmc_seq.sv
// microcode sequencer: step counter, control rom lookup and jump logic
// depends on edmc_pkg
module edmc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  edmc_pkg::seq_cond_t cond,
    output logic                busy,
    output logic                step_en,
    output edmc_pkg::ctrl_t     ctrl
);
    import edmc_pkg::*;

    logic             busy_reg;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    assign ctrl    = micro_rom(upc_reg);
    // the finishing step waits while the previous result word is still held
    assign step_en = busy_reg && !(ctrl.fin && cond.out_blocked);
    assign busy    = busy_reg;

    always_comb begin
        unique case (ctrl.jmp)
            J_NEXT:   upc_next = upc_reg + 1'b1;
            J_GOTO:   upc_next = ctrl.target;
            J_DISPATCH: begin
                priority if (cond.is_turn) begin
                    upc_next = STEP_TURN;
                end else if (cond.is_straight) begin
                    upc_next = STEP_STRAIGHT;
                end else begin
                    upc_next = STEP_FIN;
                end
            end
            default:  upc_next = STEP_FIN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            upc_reg  <= STEP_DISPATCH;
        end else if (!busy_reg) begin
            if (start) begin
                busy_reg <= 1'b1;
                upc_reg  <= STEP_DISPATCH;
            end
        end else if (step_en) begin
            if (ctrl.fin) begin
                busy_reg <= 1'b0;
            end else begin
                upc_reg <= upc_next;
            end
        end
    end

endmodule

FILE: rtl/encoder_distance_motor_ctrl.sv
// encoder distance motor controller top level: handshakes, datapath and wheel state
// depends on edmc_pkg and edmc_seq
//
// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   event word, 32 bits
// m_        out  m_tvalid/m_tready   result word, 51 bits in 56
// cfg_      in   cfg_valid/cfg_ready balance margin, 8 bits
//
// a word that carries no command runs only the dispatch and finishing steps; a turn
// command runs steps 7 to 10 and a straight command steps 1 to 6 between them; the
// microcode steps through one shared 32x32 multiplier, one product a cycle.
// reset: synchronous, active low; pwm 75, margin 1, counts zero, stopped set.
// a new word is taken once the program ends; the last step waits only while the
// previous result word is still waiting on m_tready.
module encoder_distance_motor_ctrl (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] event_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] stop_event, [1] pwm_update,
                                   // [17:2] right_pulse_width, [49:18] ticks_left_to_go,
                                   // [50] is_stopped, [55:51] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import edmc_pkg::*;

    logic        busy;
    logic        step_en;
    ctrl_t       ctrl;
    seq_cond_t   cond;
    logic        fin_fire;

    logic [31:0] word_reg;
    logic [63:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] quot_reg;
    logic [31:0] rem_reg;
    logic [31:0] left_reg;
    logic [31:0] right_reg;
    logic [15:0] pwm_reg;
    logic        stopped_reg;
    logic [7:0]  margin_reg;
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    logic [15:0] d;
    logic [7:0]  code;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_w;
    logic [31:0] divisor;
    logic [31:0] rmd;
    logic [31:0] quot_fix;

    logic [31:0] rem_next;
    logic [31:0] left_next;
    logic [31:0] right_next;
    logic [15:0] pwm_next;
    logic        stopped_next;
    logic        stop_ev;
    logic        upd;
    logic        right_lead;
    logic        left_lead;

    assign d    = word_reg[15:0];
    assign code = word_reg[15:8];

    assign cond.is_straight = (word_reg[31:24] == STRAIGHT_TAG);
    assign cond.is_turn     = ((word_reg & TURN_MASK) == TURN_MASK);
    assign cond.out_blocked = m_tvalid_reg && !m_tready;

    edmc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_tvalid && s_tready),
        .cond    (cond),
        .busy    (busy),
        .step_en (step_en),
        .ctrl    (ctrl)
    );

    assign s_tready  = !busy;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign fin_fire  = step_en && ctrl.fin;

    // shared multiplier operands
    always_comb begin
        unique case (ctrl.a_sel)
            A_D:       op_a = {16'b0, d};
            A_PROD_LO: op_a = prod_reg[31:0];
            A_PROD_HI: op_a = prod_reg[63:32];
            A_ACC:     op_a = acc_reg;
            default:   op_a = acc_reg;
        endcase
        unique case (ctrl.b_sel)
            B_D6:             op_b = {14'b0, d, 2'b0} + {15'b0, d, 1'b0};
            B_QUAD_LIN:       op_b = QUAD_LIN;
            B_TURN_MUL:       op_b = TURN_MUL;
            B_STRAIGHT_DIV:   op_b = STRAIGHT_DIV;
            B_TURN_DIV:       op_b = TURN_DIV;
            B_RECIP_STRAIGHT: op_b = RECIP_STRAIGHT;
            B_RECIP_TURN:     op_b = RECIP_TURN;
            default:          op_b = TURN_DIV;
        endcase
    end

    assign mul_w = {32'b0, op_a} * {32'b0, op_b};

    // quotient estimate is at most one low: one compare fixes it
    assign divisor  = (ctrl.div_sel == DIV_TURN) ? TURN_DIV : STRAIGHT_DIV;
    assign rmd      = acc_reg - prod_reg[31:0];
    assign quot_fix = quot_reg + {31'b0, (rmd >= divisor)};

    // tick, stop check and wheel balance of the finishing step
    always_comb begin
        rem_next   = rem_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (code == CODE_LEFT) begin
            left_next = left_reg + 32'd1;
            if (rem_reg != 32'd0) begin
                rem_next = rem_reg - 32'd1;
            end
        end else if (code == CODE_RIGHT) begin
            right_next = right_reg + 32'd1;
        end

        stop_ev      = 1'b0;
        stopped_next = stopped_reg;
        if (rem_next == 32'd0 && !stopped_reg) begin
            stopped_next = 1'b1;
            stop_ev      = 1'b1;
        end
        if (rem_next != 32'd0) begin
            stopped_next = 1'b0;
        end

        right_lead = {1'b0, right_next} > ({1'b0, left_next} + {25'b0, margin_reg});
        left_lead  = {1'b0, left_next} > ({1'b0, right_next} + {25'b0, margin_reg});
        upd        = right_lead || left_lead;
        pwm_next   = pwm_reg;
        priority if (right_lead) begin
            if (pwm_reg != 16'd0) begin
                pwm_next = pwm_reg - 16'd1;
            end
        end else if (left_lead) begin
            if (pwm_reg != PWM_MAX) begin
                pwm_next = pwm_reg + 16'd1;
            end
        end
        if (upd) begin
            left_next  = 32'd0;
            right_next = 32'd0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_tdata;
        end
        if (step_en) begin
            if (ctrl.mul_en) begin
                prod_reg <= mul_w;
            end
            unique case (ctrl.acc_op)
                ACC_HOLD: acc_reg <= acc_reg;
                ACC_LOAD: acc_reg <= prod_reg[31:0];
                ACC_SUM:  acc_reg <= acc_reg + prod_reg[31:0] - QUAD_OFFSET;
                default:  acc_reg <= acc_reg;
            endcase
            if (ctrl.quot_ld) begin
                quot_reg <= prod_reg[63:32];
            end
        end
        if (fin_fire) begin
            m_tdata_reg <= {5'b0, stopped_next, rem_next, pwm_next, upd, stop_ev};
        end
    end

    // control and wheel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 32'd0;
            left_reg     <= 32'd0;
            right_reg    <= 32'd0;
            pwm_reg      <= PWM_RESET;
            stopped_reg  <= 1'b1;
            margin_reg   <= MARGIN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                margin_reg <= cfg_data;
            end
            if (step_en && ctrl.rem_ld) begin
                rem_reg <= quot_fix;
            end
            if (fin_fire) begin
                rem_reg     <= rem_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
                pwm_reg     <= pwm_next;
                stopped_reg <= stopped_next;
            end
            if (fin_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // a finished word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten");

    // after every item the stopped flag tracks a zero remaining count
    a_stopped_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> (stopped_reg == (rem_reg == 32'd0)))
        else $error("stopped flag out of step with remaining count");

    // a trim clears both wheel counts
    a_trim_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && upd) |=> (left_reg == 32'd0 && right_reg == 32'd0))
        else $error("tick counts not cleared after trim");

    // pwm moves only on the finishing step
    a_pwm_only_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(fin_fire) |-> $stable(pwm_reg))
        else $error("pwm changed outside finishing step");

endmodule
